### src/triangle_interior_angles_defines.svh
// assertion macros for the triangle interior angles block
// used by triangle_interior_angles.sv; expects clk and arst_n in scope
`ifndef TRIANGLE_INTERIOR_ANGLES_DEFINES_SVH
`define TRIANGLE_INTERIOR_ANGLES_DEFINES_SVH
`ifndef SYNTHESIS
`define TIA_ASSERT_IMPLY(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
	else $error("%m: implication check failed");
`define TIA_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
	else $error("%m: next-cycle check failed");
`else
`define TIA_ASSERT_IMPLY(label, cond, prop)
`define TIA_ASSERT_NEXT(label, cond, prop)
`endif
`endif

### src/tia_pkg.sv
// shared types, constants and arctangent table for the triangle angles block
// no dependencies
package tia_pkg;
	localparam int COORD_BITS = 16;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ANGLE_BITS = 16;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int MAG_IDX_W = $clog2(DIFF_W);
	localparam int NORM_EXP = 33;
	localparam int SHAMT_W = 6;
	localparam int VEC_W = NORM_EXP + 5;
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_W = 5;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam int ANGLE_MAX = ((180 << ANGLE_FRAC_BITS) > 65535) ? 65535 :
		(180 << ANGLE_FRAC_BITS);

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_x;
		logic signed [COORD_BITS-1:0] first_y;
		logic signed [COORD_BITS-1:0] second_x;
		logic signed [COORD_BITS-1:0] second_y;
		logic signed [COORD_BITS-1:0] third_x;
		logic signed [COORD_BITS-1:0] third_y;
	} tri_in_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle_at_third;
		logic [ANGLE_BITS-1:0] angle_at_first;
		logic [ANGLE_BITS-1:0] angle_at_second;
		logic                  degenerate;
	} tri_out_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [31:0]             z;
	} lane_t;

	// lane 0 edge first-second, lane 1 second-third, lane 2 third-first
	typedef struct packed {
		lane_t [2:0] lane;
		logic        degen;
	} cell_data_t;
endpackage

### src/tia_prep.sv
// edge vectors, degeneracy test, normalization and half-plane fold
// depends on tia_pkg
module tia_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tri_valid,
	input  tia_pkg::tri_in_t    tri_data,
	input  logic                next_ready,
	output logic                ready,
	output logic                valid,
	output tia_pkg::cell_data_t data
);
	import tia_pkg::*;

	logic signed [DIFF_W-1:0] dx [3];
	logic signed [DIFF_W-1:0] dy [3];
	cell_data_t d_next;
	logic valid_q;
	cell_data_t data_q;

	// edge differences
	always_comb begin
		dx[0] = DIFF_W'(tri_data.second_x) - DIFF_W'(tri_data.first_x);
		dy[0] = DIFF_W'(tri_data.second_y) - DIFF_W'(tri_data.first_y);
		dx[1] = DIFF_W'(tri_data.third_x) - DIFF_W'(tri_data.second_x);
		dy[1] = DIFF_W'(tri_data.third_y) - DIFF_W'(tri_data.second_y);
		dx[2] = DIFF_W'(tri_data.first_x) - DIFF_W'(tri_data.third_x);
		dy[2] = DIFF_W'(tri_data.first_y) - DIFF_W'(tri_data.third_y);
	end

	// scale each vector so its larger component reaches 2^33, then fold x >= 0
	always_comb begin
		logic [DIFF_W-1:0] ax, ay, m;
		logic [MAG_IDX_W-1:0] p;
		logic [SHAMT_W-1:0] sh;
		logic signed [VEC_W-1:0] x, y;
		d_next = '0;
		for (int l = 0; l < 3; l++) begin
			ax = dx[l][DIFF_W-1] ? DIFF_W'(-dx[l]) : DIFF_W'(dx[l]);
			ay = dy[l][DIFF_W-1] ? DIFF_W'(-dy[l]) : DIFF_W'(dy[l]);
			m = (ax > ay) ? ax : ay;
			p = '0;
			for (int k = 0; k < DIFF_W; k++) begin
				if (m[k]) begin
					p = MAG_IDX_W'(k);
				end
			end
			sh = SHAMT_W'(NORM_EXP - int'(p));
			x = VEC_W'(dx[l]) <<< sh;
			y = VEC_W'(dy[l]) <<< sh;
			if (x < 0) begin
				d_next.lane[l].x = -x;
				d_next.lane[l].y = -y;
				d_next.lane[l].z = HALF_TURN;
			end else begin
				d_next.lane[l].x = x;
				d_next.lane[l].y = y;
				d_next.lane[l].z = '0;
			end
		end
		d_next.degen = ((dx[0] == 0) && (dy[0] == 0)) || ((dx[1] == 0) && (dy[1] == 0)) ||
			((dx[2] == 0) && (dy[2] == 0));
	end

	assign ready = !valid_q || next_ready;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= tri_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && tri_valid) begin
			data_q <= d_next;
		end
	end

	assign valid = valid_q;
	assign data = data_q;
endmodule

### src/tia_cell.sv
// one cordic vectoring iteration for three lanes, with its own stage register
// depends on tia_pkg
module tia_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tia_pkg::STEP_W-1:0] shift,
	input  logic [31:0]                atan,
	input  logic                       prev_valid,
	input  tia_pkg::cell_data_t        prev_data,
	input  logic                       next_ready,
	output logic                       ready,
	output logic                       valid,
	output tia_pkg::cell_data_t        data
);
	import tia_pkg::*;

	cell_data_t d_next;
	logic valid_q;
	cell_data_t data_q;

	// rotate toward the x axis, accumulate angle
	always_comb begin
		logic signed [VEC_W-1:0] xs, ys;
		d_next = prev_data;
		for (int l = 0; l < 3; l++) begin
			xs = prev_data.lane[l].x >>> shift;
			ys = prev_data.lane[l].y >>> shift;
			if (!prev_data.lane[l].y[VEC_W-1]) begin
				d_next.lane[l].x = prev_data.lane[l].x + ys;
				d_next.lane[l].y = prev_data.lane[l].y - xs;
				d_next.lane[l].z = prev_data.lane[l].z + atan;
			end else begin
				d_next.lane[l].x = prev_data.lane[l].x - ys;
				d_next.lane[l].y = prev_data.lane[l].y + xs;
				d_next.lane[l].z = prev_data.lane[l].z - atan;
			end
		end
	end

	assign ready = !valid_q || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && prev_valid) begin
			data_q <= d_next;
		end
	end

	assign valid = valid_q;
	assign data = data_q;
endmodule

### src/tia_post.sv
// direction differences to degrees, output register
// depends on tia_pkg
module tia_post (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                prev_valid,
	input  tia_pkg::cell_data_t prev_data,
	input  logic                ang_stall,
	output logic                ready,
	output logic                ang_valid,
	output tia_pkg::tri_out_t   ang_data
);
	import tia_pkg::*;

	localparam int PROD_W = 32 + 8 + ANGLE_FRAC_BITS + 1;

	logic [31:0] e12, e23, e31;
	tri_out_t r_next;
	logic valid_q;
	tri_out_t data_q;

	// wrapped difference folded to half a turn, scaled and rounded
	function automatic logic [ANGLE_BITS-1:0] to_deg(input logic [31:0] d1,
			input logic [31:0] d2);
		logic [31:0] d;
		logic [39:0] prod;
		logic [PROD_W-1:0] r;
		d = d1 - d2;
		if (d > HALF_TURN) begin
			d = 32'(0 - d);
		end
		prod = 40'(d) * 8'd180;
		r = (PROD_W'(prod) << ANGLE_FRAC_BITS) + (PROD_W'(1) << 30);
		r = r >> 31;
		return (r > PROD_W'(16'hFFFF)) ? 16'hFFFF : r[ANGLE_BITS-1:0];
	endfunction

	assign e12 = prev_data.lane[0].z;
	assign e23 = prev_data.lane[1].z;
	assign e31 = prev_data.lane[2].z;

	always_comb begin
		r_next.degenerate = prev_data.degen;
		if (prev_data.degen) begin
			r_next.angle_at_third = '0;
			r_next.angle_at_first = '0;
			r_next.angle_at_second = '0;
		end else begin
			r_next.angle_at_third = to_deg(e31, e23 + HALF_TURN);
			r_next.angle_at_first = to_deg(e12, e31 + HALF_TURN);
			r_next.angle_at_second = to_deg(e12 + HALF_TURN, e23);
		end
	end

	assign ready = !valid_q || !ang_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && prev_valid) begin
			data_q <= r_next;
		end
	end

	assign ang_valid = valid_q;
	assign ang_data = data_q;
endmodule

### src/triangle_interior_angles.sv
// top level: triangle interior angles by cordic edge directions
// depends on tia_pkg, tia_prep, tia_cell, tia_post and the defines header
//
//  channel   signals                        direction  payload
//  triangle  tri_valid tri_stall tri_data   in         tri_in_t
//  angles    ang_valid ang_stall ang_data   out        tri_out_t
//
// one transaction per cycle when nothing stalls; registers in order: prep stage,
// 28 cordic cells, output stage
// every stage register (prep, cell, output) takes a new item per cycle while it is empty or the next stage is ready
// arst_n clears every stage valid bit; payload registers are not reset
// ang_stall freezes only the full stages behind it, empty stages keep filling
`include "triangle_interior_angles_defines.svh"
module triangle_interior_angles (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tri_valid,
	output logic              tri_stall,
	input  tia_pkg::tri_in_t  tri_data,
	output logic              ang_valid,
	input  logic              ang_stall,
	output tia_pkg::tri_out_t ang_data
);
	import tia_pkg::*;

	logic [CORDIC_STEPS:0] stage_valid;
	logic [CORDIC_STEPS+1:0] stage_ready;
	cell_data_t stage_data [CORDIC_STEPS+1];

	// front stage
	tia_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.tri_valid  (tri_valid),
		.tri_data   (tri_data),
		.next_ready (stage_ready[1]),
		.ready      (stage_ready[0]),
		.valid      (stage_valid[0]),
		.data       (stage_data[0])
	);

	assign tri_stall = !stage_ready[0];

	// row of cordic cells
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		tia_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (STEP_W'(i)),
			.atan       (ATAN_TAB[i]),
			.prev_valid (stage_valid[i]),
			.prev_data  (stage_data[i]),
			.next_ready (stage_ready[i+2]),
			.ready      (stage_ready[i+1]),
			.valid      (stage_valid[i+1]),
			.data       (stage_data[i+1])
		);
	end

	// conversion and output register
	tia_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (stage_valid[CORDIC_STEPS]),
		.prev_data  (stage_data[CORDIC_STEPS]),
		.ang_stall  (ang_stall),
		.ready      (stage_ready[CORDIC_STEPS+1]),
		.ang_valid  (ang_valid),
		.ang_data   (ang_data)
	);

	// checks
	`TIA_ASSERT_IMPLY(a_degen_zero, ang_valid && ang_data.degenerate, (ang_data.angle_at_third == 0) && (ang_data.angle_at_first == 0) && (ang_data.angle_at_second == 0))
	`TIA_ASSERT_IMPLY(a_angle_range, ang_valid && !ang_data.degenerate, (32'(ang_data.angle_at_third) <= ANGLE_MAX) && (32'(ang_data.angle_at_first) <= ANGLE_MAX) && (32'(ang_data.angle_at_second) <= ANGLE_MAX))
	`TIA_ASSERT_NEXT(a_prep_moves, stage_valid[0] && !stage_valid[1], stage_valid[1])
	`TIA_ASSERT_NEXT(a_row_drains, stage_valid[CORDIC_STEPS] && !ang_valid, ang_valid)
endmodule

### tb/sv/tb.sv
// testbench for triangle_interior_angles: random and directed triangles checked
// against an in-bench cordic angle predictor; depends on tia_pkg and the block
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tia_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [31:0] ARCTAN [28] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tri_valid = 1'b0;
	logic tri_stall;
	tri_in_t tri_data = '0;
	logic ang_valid;
	logic ang_stall = 1'b0;
	tri_out_t ang_data;

	tri_in_t pending_tris[$];
	tri_out_t expected_angles[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int degen_seen = 0;
	int cycle = 0;
	int phase = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	triangle_interior_angles uut (.*);

	always #4 clk = ~clk;

	// edge direction as a 32-bit binary angle via cordic vectoring
	function automatic logic [31:0] edge_dir(longint ex, longint ey);
		longint xs;
		longint ys;
		logic [31:0] z;
		z = '0;
		for (int n = 0; n < 40; n++) begin
			if ((ex < 0 ? -ex : ex) >= (64'sd1 <<< 33) || (ey < 0 ? -ey : ey) >= (64'sd1 <<< 33))
				break;
			ex = ex * 2;
			ey = ey * 2;
		end
		if (ex < 0) begin
			ex = -ex;
			ey = -ey;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < 28; i++) begin
			xs = ex >>> i;
			ys = ey >>> i;
			if (ey >= 0) begin
				ex = ex + ys;
				ey = ey - xs;
				z = z + ARCTAN[i];
			end else begin
				ex = ex - ys;
				ey = ey + xs;
				z = z - ARCTAN[i];
			end
		end
		return z;
	endfunction

	// folded direction difference scaled to degrees with fraction bits
	function automatic logic [15:0] corner_angle(logic [31:0] d1, logic [31:0] d2);
		logic [31:0] d;
		logic [63:0] r;
		d = d1 - d2;
		if (d > 32'h8000_0000)
			d = 32'd0 - d;
		r = ((64'(d) * 64'd180 << ANGLE_FRAC_BITS) + (64'd1 << 30)) >> 31;
		return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic tri_out_t predict_angles(tri_in_t t);
		longint ax, ay, bx, by, cx, cy;
		logic [31:0] e12, e23, e31;
		tri_out_t o;
		ax = longint'(t.second_x) - longint'(t.first_x);
		ay = longint'(t.second_y) - longint'(t.first_y);
		bx = longint'(t.third_x) - longint'(t.second_x);
		by = longint'(t.third_y) - longint'(t.second_y);
		cx = longint'(t.first_x) - longint'(t.third_x);
		cy = longint'(t.first_y) - longint'(t.third_y);
		o = '0;
		if ((ax == 0 && ay == 0) || (bx == 0 && by == 0) || (cx == 0 && cy == 0)) begin
			o.degenerate = 1'b1;
			return o;
		end
		e12 = edge_dir(ax, ay);
		e23 = edge_dir(bx, by);
		e31 = edge_dir(cx, cy);
		o.angle_at_third = corner_angle(e31, e23 + 32'h8000_0000);
		o.angle_at_first = corner_angle(e12, e31 + 32'h8000_0000);
		o.angle_at_second = corner_angle(e12 + 32'h8000_0000, e23);
		return o;
	endfunction

	function automatic tri_in_t make_tri(int x1, int y1, int x2, int y2, int x3, int y3);
		tri_in_t t;
		t.first_x = 16'(x1);
		t.first_y = 16'(y1);
		t.second_x = 16'(x2);
		t.second_y = 16'(y2);
		t.third_x = 16'(x3);
		t.third_y = 16'(y3);
		return t;
	endfunction

	function automatic logic [15:0] rand_coord(int spread);
		int r;
		if (spread == 0)
			return 16'($urandom);
		r = $urandom_range(0, 2 * spread);
		return 16'(r - spread);
	endfunction

	// append one triangle to the stimulus queue
	task automatic queue_tri(input tri_in_t t);
		pending_tris = {pending_tris, t};
	endtask

	// stimulus: directed corners, then random triangles at mixed scales
	initial begin
		tri_in_t t;
		int kind;
		queue_tri(make_tri(0, 0, 0, 0, 0, 0));
		queue_tri(make_tri(1, 2, 1, 2, 5, 7));
		queue_tri(make_tri(1, 2, 5, 7, 5, 7));
		queue_tri(make_tri(5, 7, 1, 2, 5, 7));
		queue_tri(make_tri(0, 0, 1, 0, 0, 1));
		queue_tri(make_tri(0, 0, 2, 0, 1, 1732));
		queue_tri(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
		queue_tri(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
		queue_tri(make_tri(-32768, -32768, 32767, 32767, 0, 0));
		queue_tri(make_tri(-32768, 0, 32767, 0, 0, 1));
		queue_tri(make_tri(0, 0, 1, 1, 2, 2));
		queue_tri(make_tri(0, 0, 1, 0, -1, 0));
		queue_tri(make_tri(-1, -1, 0, -1, -1, 0));
		queue_tri(make_tri(32767, -32768, -32768, 32767, 32767, 32767));
		queue_tri(make_tri(0, 0, 3, 0, 0, 4));
		queue_tri(make_tri(0, 0, -3, 0, 0, -4));
		queue_tri(make_tri(100, -5, -100, -4, 0, 32767));
		queue_tri(make_tri(-21846, 21845, 21845, -21846, 0, 1));
		for (int i = 0; i < 1750; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					t = {rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
						rand_coord(0), rand_coord(0)};
				end
				4, 5: begin
					t = {rand_coord(8), rand_coord(8), rand_coord(8), rand_coord(8),
						rand_coord(8), rand_coord(8)};
				end
				6: begin
					// collinear or repeated vertex
					t = {rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
						16'd0, 16'd0};
					if ($urandom_range(0, 1)) begin
						t.third_x = t.first_x;
						t.third_y = t.first_y;
					end else begin
						t.third_x = 16'(2 * int'(t.second_x) - int'(t.first_x));
						t.third_y = 16'(2 * int'(t.second_y) - int'(t.first_y));
					end
				end
				7: begin
					t = {rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
						rand_coord(2), rand_coord(2)};
				end
				default: begin
					t = {rand_coord(300), rand_coord(300), rand_coord(0), rand_coord(0),
						rand_coord(300), rand_coord(300)};
				end
			endcase
			queue_tri(t);
		end
	end

	// reset, cycle count, idling phases and cycle-limit stop
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == 2)
			arst_n <= 1'b1;
		if (sent == 600)
			phase <= 1;
		else if (sent == 1200)
			phase <= 2;
		if (cycle >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		bit take;
		bit idle;
		if (arst_n) begin
			take = tri_valid && !tri_stall;
			if (take)
				sent <= sent + 1;
			if (!tri_valid || take) begin
				idle = (phase == 0) ? ($urandom_range(0, 99) < 12) :
					(phase == 1) ? ($urandom_range(0, 99) < 73) : 1'b0;
				// one drain pause halfway through
				if ((sent + int'(take)) == 900 && !hold_off && expected_angles.size() > 0) begin
					idle = 1'b1;
				end else if ((sent + int'(take)) == 900) begin
					hold_off <= 1'b1;
				end
				if (pending_tris.size() > 0 && !idle) begin
					tri_data <= pending_tris[0];
					expected_angles = {expected_angles, predict_angles(pending_tris[0])};
					void'(pending_tris.pop_front());
					tri_valid <= 1'b1;
				end else begin
					tri_valid <= 1'b0;
					if (pending_tris.size() == 0 && sent > 0)
						stim_done <= 1'b1;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		tri_out_t exp_o;
		if (arst_n) begin
			ang_stall <= (phase == 0) ? ($urandom_range(0, 99) < 73) :
				(phase == 1) ? ($urandom_range(0, 99) < 12) : 1'b0;
			if (ang_valid && !ang_stall) begin
				if (expected_angles.size() == 0) begin
					$error("unexpected transaction: %h", ang_data);
					errors = errors + 1;
				end else begin
					exp_o = expected_angles.pop_front();
					checked <= checked + 1;
					if (exp_o.degenerate)
						degen_seen <= degen_seen + 1;
					if (ang_data.angle_at_third !== exp_o.angle_at_third) begin
						$error("angle_at_third expected %0d got %0d", exp_o.angle_at_third,
							ang_data.angle_at_third);
						errors = errors + 1;
					end
					if (ang_data.angle_at_first !== exp_o.angle_at_first) begin
						$error("angle_at_first expected %0d got %0d", exp_o.angle_at_first,
							ang_data.angle_at_first);
						errors = errors + 1;
					end
					if (ang_data.angle_at_second !== exp_o.angle_at_second) begin
						$error("angle_at_second expected %0d got %0d", exp_o.angle_at_second,
							ang_data.angle_at_second);
						errors = errors + 1;
					end
					if (ang_data.degenerate !== exp_o.degenerate) begin
						$error("degenerate expected %0d got %0d", exp_o.degenerate,
							ang_data.degenerate);
						errors = errors + 1;
					end
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done && !tri_valid);
		wait (expected_angles.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d triangles, %0d degenerate, under three stall mixes",
			checked, degen_seen);
		if (errors == 0 && expected_angles.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
